>>> hw/rtl/byte_pipe_fifo_with_end_close_core_defines.svh
// Assertion macros for the byte pipe core.
// BPF_ASSERT checks a property on clk while rst is low.
// BPF_ASSERT_RST checks a property on clk, during reset as well.
`ifndef BYTE_PIPE_FIFO_WITH_END_CLOSE_CORE_DEFINES_SVH
`define BYTE_PIPE_FIFO_WITH_END_CLOSE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");
`define BPF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");
`else
`define BPF_ASSERT(lbl, prop)
`define BPF_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hw/rtl/bpf_pkg.sv
`default_nettype none
package bpf_pkg;

  localparam int DEPTH_DEFAULT = 512;

  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_READ     = 3'd1,
    OP_CLOSE_WR = 3'd2,
    OP_CLOSE_RD = 3'd3,
    OP_REOPEN   = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_EMPTY_BLOCK   = 3'd1,
    ST_END_OF_STREAM = 3'd2,
    ST_FULL_BLOCK    = 3'd3,
    ST_BROKEN        = 3'd4,
    ST_END_CLOSED    = 3'd5
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/bpf_if.sv
`default_nettype none
// Command channel: one pipe operation per beat.
interface bpf_cmd_if;
  import bpf_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, output opcode, output write_data, input ready);
  modport sink   (input valid, input opcode, input write_data, output ready);
endinterface

// Response channel: one result per beat.
interface bpf_rsp_if;
  import bpf_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, output read_data, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input read_data, input status, input fill_level,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/byte_pipe_fifo_with_end_close_core.sv
`default_nettype none
`include "byte_pipe_fifo_with_end_close_core_defines.svh"
// Byte pipe core: a ring buffer of DEPTH bytes with a write end and a read end.
// Every command beat carries one operation (write a byte, read a byte, close
// the write end, close the read end, reopen) and produces exactly one response
// beat with the byte read, a status code and the fill level after the
// operation. Nothing ever waits inside the block: a write into a full buffer
// answers "full would block" (or "broken pipe" once the reader is closed),
// and a read from an empty buffer answers "empty would block" (or "end of
// stream" once the writer is closed). The block takes one command per clock
// cycle and answers it in the next cycle; the response sits in an output
// register, and a new command is taken in the same cycle that the waiting
// response is taken, so a consumer that is always ready sees one beat per
// cycle. The byte read comes from the synchronous read port of the byte store,
// whose registered output feeds the read_data field. Reopen empties
// the pipe by clearing the pointers only; stale bytes stay in the store but
// can no longer be reached. No clearing pass is needed after reset.
module byte_pipe_fifo_with_end_close_core #(
  parameter int DEPTH = bpf_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  bpf_cmd_if.sink   cmd,
  bpf_rsp_if.source rsp
);
  import bpf_pkg::*;

  // Entry index width, and a fill count that can hold DEPTH itself.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  // Pointers are an entry index plus a lap bit, which together count
  // modulo twice the depth.
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [AW-1:0] wr_idx, wr_idx_next;
  logic          rd_lap, rd_lap_next;
  logic          wr_lap, wr_lap_next;
  logic          reader_open, reader_open_next;
  logic          writer_open, writer_open_next;

  // Byte store with one write port and one registered read port.
  logic [DATA_W-1:0] ring_store [DEPTH];
  logic [DATA_W-1:0] mem_rdata;
  logic              mem_we;
  logic              mem_re;

  // Response register.
  logic                rsp_valid;
  logic                data_sel, data_sel_next;
  status_t             status_q, status_next;
  logic [FILL_W-1:0]   fill_q;

  logic          cmd_fire;
  logic [CW-1:0] fill_cur;
  logic [CW-1:0] fill_next;
  logic          empty;
  logic          full;
  logic          rd_ok;

  function automatic logic [CW-1:0] fill_of(input logic [AW-1:0] w, input logic w_lap,
                                            input logic [AW-1:0] r, input logic r_lap);
    logic [CW-1:0] diff;
    diff = {1'b0, w} - {1'b0, r};
    if (w_lap != r_lap) begin
      diff = diff + DEPTH_CNT;
    end
    return diff;
  endfunction

  assign cmd.ready = !rsp_valid || rsp.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign fill_cur = fill_of(wr_idx, wr_lap, rd_idx, rd_lap);
  assign empty    = (fill_cur == '0);
  assign full     = (fill_cur >= DEPTH_CNT);

  // Operation decode: pointer and end updates, status, store access.
  always_comb begin
    rd_idx_next      = rd_idx;
    wr_idx_next      = wr_idx;
    rd_lap_next      = rd_lap;
    wr_lap_next      = wr_lap;
    reader_open_next = reader_open;
    writer_open_next = writer_open;
    status_next      = ST_OK;
    mem_we           = 1'b0;
    rd_ok            = 1'b0;

    case (opcode_t'(cmd.opcode))
      OP_WRITE: begin
        if (!writer_open) begin
          status_next = ST_END_CLOSED;
        end else if (full) begin
          status_next = reader_open ? ST_FULL_BLOCK : ST_BROKEN;
        end else begin
          mem_we = cmd_fire;
          if (wr_idx == LAST_IDX) begin
            wr_idx_next = '0;
            wr_lap_next = !wr_lap;
          end else begin
            wr_idx_next = wr_idx + AW'(1);
          end
        end
      end
      OP_READ: begin
        if (!reader_open) begin
          status_next = ST_END_CLOSED;
        end else if (empty) begin
          status_next = writer_open ? ST_EMPTY_BLOCK : ST_END_OF_STREAM;
        end else begin
          rd_ok = 1'b1;
          if (rd_idx == LAST_IDX) begin
            rd_idx_next = '0;
            rd_lap_next = !rd_lap;
          end else begin
            rd_idx_next = rd_idx + AW'(1);
          end
        end
      end
      OP_CLOSE_WR: begin
        if (!writer_open) begin
          status_next = ST_END_CLOSED;
        end
        writer_open_next = 1'b0;
      end
      OP_CLOSE_RD: begin
        if (!reader_open) begin
          status_next = ST_END_CLOSED;
        end
        reader_open_next = 1'b0;
      end
      OP_REOPEN: begin
        rd_idx_next      = '0;
        wr_idx_next      = '0;
        rd_lap_next      = 1'b0;
        wr_lap_next      = 1'b0;
        reader_open_next = 1'b1;
        writer_open_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mem_re        = cmd_fire && rd_ok;
  assign data_sel_next = rd_ok;
  assign fill_next     = fill_of(wr_idx_next, wr_lap_next, rd_idx_next, rd_lap_next);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_store[wr_idx] <= cmd.write_data;
    end
    if (mem_re) begin
      mem_rdata <= ring_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx      <= '0;
      wr_idx      <= '0;
      rd_lap      <= 1'b0;
      wr_lap      <= 1'b0;
      reader_open <= 1'b1;
      writer_open <= 1'b1;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd_fire) begin
        rd_idx      <= rd_idx_next;
        wr_idx      <= wr_idx_next;
        rd_lap      <= rd_lap_next;
        wr_lap      <= wr_lap_next;
        reader_open <= reader_open_next;
        writer_open <= writer_open_next;
        rsp_valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid   <= 1'b0;
      end
    end
  end

  // Response payload; the byte itself comes straight from the store's read register.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      data_sel <= data_sel_next;
      status_q <= status_next;
      fill_q   <= FILL_W'(fill_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_data  = data_sel ? mem_rdata : '0;
  assign rsp.status     = status_q;
  assign rsp.fill_level = fill_q;

  `BPF_ASSERT(a_fill_bounded, fill_cur <= DEPTH_CNT)
  `BPF_ASSERT(a_no_write_when_full, mem_we |-> !full && writer_open)
  `BPF_ASSERT(a_read_only_nonempty, mem_re |-> !empty && reader_open)
  `BPF_ASSERT(a_cmd_gives_rsp, cmd_fire |=> rsp_valid)
  `BPF_ASSERT_RST(a_reset_clears_rsp, rst |=> !rsp_valid)

endmodule
`default_nettype wire
